@@ rtl/bec_pkg.sv @@
// ----------------------------------------------------------------------------
// bec_pkg
// Character constants and lookup functions for the backslash escape codec.
// ----------------------------------------------------------------------------
package bec_pkg;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_DQUOT = 8'h22;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_SQUOT = 8'h27;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_LOW_N = 8'h6E;
    localparam logic [7:0] CH_LOW_P = 8'h70;
    localparam logic [7:0] CH_LOW_Q = 8'h71;
    localparam logic [7:0] CH_LOW_R = 8'h72;
    localparam logic [7:0] CH_LOW_S = 8'h73;
    localparam logic [7:0] CH_LOW_T = 8'h74;

    localparam logic DIR_ESCAPE   = 1'b0;
    localparam logic DIR_UNESCAPE = 1'b1;

    // letter for a special byte, NUL when the byte is copied as is
    function automatic logic [7:0] esc_letter(input logic [7:0] b);
        logic [7:0] m;
        case (b)
            CH_BSL:   m = CH_BSL;
            CH_LF:    m = CH_LOW_N;
            CH_CR:    m = CH_LOW_R;
            CH_TAB:   m = CH_LOW_T;
            CH_DQUOT: m = CH_LOW_Q;
            CH_SQUOT: m = CH_LOW_S;
            CH_PCT:   m = CH_LOW_P;
            default:  m = CH_NUL;
        endcase
        return m;
    endfunction

    // byte for an escape letter, NUL when the letter is unknown
    function automatic logic [7:0] unesc_byte(input logic [7:0] b);
        logic [7:0] m;
        case (b)
            CH_LOW_N: m = CH_LF;
            CH_LOW_R: m = CH_CR;
            CH_LOW_T: m = CH_TAB;
            CH_LOW_Q: m = CH_DQUOT;
            CH_LOW_S: m = CH_SQUOT;
            CH_BSL:   m = CH_BSL;
            CH_LOW_P: m = CH_PCT;
            default:  m = CH_NUL;
        endcase
        return m;
    endfunction

endpackage

@@ rtl/backslash_escape_codec.sv @@
// Latency: a result is presented the cycle after its input byte is accepted.
// Throughput: one input byte per cycle while m_ready is high and the byte
// yields at most one byte; a byte that yields two bytes holds the input side
// until the first byte is taken (the result port moves one byte per cycle).
// Reset (aresetn low, synchronous): direction escape, no escape pending,
// result register empty.
// ----------------------------------------------------------------------------
// backslash_escape_codec
// Escapes or unescapes a byte stream with backslash sequences; one result
// register plus a second-byte register carry up to two bytes per input.
// ----------------------------------------------------------------------------
module backslash_escape_codec (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_we,
    input  logic       cfg_wdata,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_run_last
);

    logic       direction_reg;
    logic       pending_reg,     pending_next;
    logic       m_valid_reg,     m_valid_next;
    logic [7:0] out_byte_reg,    out_byte_next;
    logic       run_last_reg,    run_last_next;
    logic       second_valid_reg, second_valid_next;
    logic [7:0] second_byte_reg, second_byte_next;

    logic       s_xfer;
    logic       m_xfer;
    logic [1:0] res_cnt;
    logic [7:0] res_b0;
    logic [7:0] res_b1;
    logic [7:0] esc_m;
    logic [7:0] unesc_m;
    logic       res_pending;

    assign s_ready = (!m_valid_reg || m_ready) && !second_valid_reg;
    assign s_xfer  = s_valid && s_ready;
    assign m_xfer  = m_valid_reg && m_ready;

    assign esc_m   = bec_pkg::esc_letter(s_in_byte);
    assign unesc_m = bec_pkg::unesc_byte(s_in_byte);

    always_comb begin
        res_cnt     = 2'd1;
        res_b0      = s_in_byte;
        res_b1      = s_in_byte;
        res_pending = pending_reg;
        if (direction_reg == bec_pkg::DIR_ESCAPE) begin
            if (esc_m != bec_pkg::CH_NUL) begin
                res_cnt = 2'd2;
                res_b0  = bec_pkg::CH_BSL;
                res_b1  = esc_m;
            end
        end else if (!pending_reg) begin
            if (s_in_byte == bec_pkg::CH_BSL) begin
                res_cnt     = 2'd0;
                res_pending = 1'b1;
            end
        end else begin
            res_pending = 1'b0;
            if (s_in_byte == bec_pkg::CH_NUL) begin
                res_b0 = bec_pkg::CH_NUL;
            end else if (unesc_m != bec_pkg::CH_NUL) begin
                res_b0 = unesc_m;
            end else begin
                res_cnt = 2'd2;
                res_b0  = bec_pkg::CH_BSL;
                res_b1  = s_in_byte;
            end
        end
    end

    always_comb begin
        pending_next      = pending_reg;
        m_valid_next      = m_valid_reg;
        out_byte_next     = out_byte_reg;
        run_last_next     = run_last_reg;
        second_valid_next = second_valid_reg;
        second_byte_next  = second_byte_reg;
        if (m_xfer) begin
            m_valid_next = 1'b0;
            if (second_valid_reg) begin
                m_valid_next      = 1'b1;
                out_byte_next     = second_byte_reg;
                run_last_next     = 1'b1;
                second_valid_next = 1'b0;
            end
        end
        if (s_xfer) begin
            pending_next = res_pending;
            case (res_cnt)
                2'd1: begin
                    m_valid_next  = 1'b1;
                    out_byte_next = res_b0;
                    run_last_next = 1'b1;
                end
                2'd2: begin
                    m_valid_next      = 1'b1;
                    out_byte_next     = res_b0;
                    run_last_next     = 1'b0;
                    second_valid_next = 1'b1;
                    second_byte_next  = res_b1;
                end
                default: begin
                end
            endcase
        end
        if (cfg_we) begin
            pending_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            direction_reg    <= bec_pkg::DIR_ESCAPE;
            pending_reg      <= 1'b0;
            m_valid_reg      <= 1'b0;
            second_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                direction_reg <= cfg_wdata;
            end
            pending_reg      <= pending_next;
            m_valid_reg      <= m_valid_next;
            second_valid_reg <= second_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_byte_reg    <= out_byte_next;
        run_last_reg    <= run_last_next;
        second_byte_reg <= second_byte_next;
    end

    assign m_valid    = m_valid_reg;
    assign m_out_byte = out_byte_reg;
    assign m_run_last = run_last_reg;

    a_second_behind_first: assert property (@(posedge aclk) disable iff (!aresetn)
        second_valid_reg |-> (m_valid_reg && !run_last_reg))
        else $error("second byte held without an open first byte");

    a_cfg_clears_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_we |=> !pending_reg)
        else $error("escape pending survived a direction write");

    a_escape_always_emits: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_xfer && direction_reg == bec_pkg::DIR_ESCAPE) |=> m_valid_reg)
        else $error("escape mode transfer produced no result");

endmodule
